// ----- rtl/core/cts_pkg.sv -----
package cts_pkg;

    localparam int CFG_ADDR_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_NUMBER_ALL      = 3'd0,
        REG_NUMBER_NONBLANK = 3'd1,
        REG_SQUEEZE_BLANK   = 3'd2,
        REG_SHOW_ENDS       = 3'd3,
        REG_SHOW_TABS       = 3'd4,
        REG_SHOW_NONPRINT   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic number_all;
        logic number_nonblank;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprint;
    } cfg_t;

    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_QMARK  = 8'h3F;
    localparam logic [7:0] CHAR_I      = 8'h49;
    localparam logic [7:0] CHAR_M      = 8'h4D;
    localparam logic [7:0] CHAR_CARET  = 8'h5E;
    localparam logic [7:0] CHAR_DEL    = 8'h7F;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [7:0] META_LOW    = 8'h80;
    localparam logic [7:0] META_HIGH   = 8'hA0;
    localparam logic [7:0] CARET_OFS   = 8'h40;
    localparam logic [7:0] META_OFS    = 8'h80;

endpackage

// ----- rtl/core/cat_text_stream_filter.sv -----
// Channel   Dir  Beat contents
// s_axis    in   tdata[7:0] data_byte, tuser[0] first_of_file
// m_axis    out  tdata[7:0] out_byte, tlast last_of_run
// cfg       in   cfg_wr_en, cfg_index, cfg_wdata[0] (register value)
//
// Each accepted input beat is expanded into a result buffer of NUMBER_DIGITS+5
// byte slots; the buffer then sends one byte per cycle while m_tready is high.
// The next input beat is taken in the cycle the last byte of the previous one
// leaves. A squeezed blank line is accepted and yields no beat.
// aresetn is synchronous, active low; it resets the mode flags and the line
// state and empties the buffer. m_tready low holds the current byte and stalls
// the input.
module cat_text_stream_filter #(
    parameter int NUMBER_DIGITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic [0:0]                    s_tuser,   // [0] first_of_file
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_byte
    output logic                          m_tlast,
    input  logic                          cfg_wr_en,
    input  logic [cts_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [0:0]                    cfg_wdata
);

    localparam int SEQ_LEN = NUMBER_DIGITS + 5;
    localparam int IDX_W   = $clog2(SEQ_LEN);
    localparam int BCD_W   = 4 * NUMBER_DIGITS;
    localparam int PAD_W   = 6;

    cts_pkg::cfg_t       cfg_reg;
    logic                prev_nl_reg;
    logic [1:0]          blank_run_reg;
    logic [BCD_W-1:0]    line_bcd_reg;
    logic                busy_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    end_reg;
    logic [7:0]          seq_reg [SEQ_LEN];

    logic                s_take;
    logic                m_take;
    logic                last_take;
    logic                first;
    logic                is_nl;
    logic                eff_prev;
    logic [1:0]          eff_run;
    logic [BCD_W-1:0]    eff_num;
    logic                squeeze_hit;
    logic [1:0]          run_next;
    logic                drop;
    logic                number_on;
    logic [BCD_W-1:0]    num_inc;
    logic [NUMBER_DIGITS-1:0] zero_from;
    logic [IDX_W-1:0]    lead_cnt;
    logic [IDX_W-1:0]    start_next;
    logic [IDX_W-1:0]    end_next;
    logic [2:0]          tail_len;
    logic [7:0]          seq_next [SEQ_LEN];

    always_comb begin
        logic       zero_acc;
        logic       carry;
        logic [3:0] dig;
        logic [7:0] ch;

        first    = s_tuser[0];
        is_nl    = (s_tdata == cts_pkg::CHAR_NL);
        eff_prev = first | prev_nl_reg;
        eff_run  = first ? 2'd0 : blank_run_reg;
        eff_num  = first ? BCD_W'(1) : line_bcd_reg;

        squeeze_hit = cfg_reg.squeeze_blank && is_nl && eff_prev;
        if (squeeze_hit) begin
            run_next = (eff_run == 2'd3) ? 2'd3 : eff_run + 2'd1;
        end else begin
            run_next = 2'd0;
        end
        drop = squeeze_hit && (run_next > 2'd1);

        number_on = eff_prev &&
                    ((cfg_reg.number_all && !cfg_reg.number_nonblank) ||
                     (cfg_reg.number_nonblank && !is_nl));

        // BCD count-up with wrap from all nines
        carry = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            dig = eff_num[4*i +: 4];
            if (carry && dig == 4'd9) begin
                num_inc[4*i +: 4] = 4'd0;
            end else begin
                num_inc[4*i +: 4] = dig + {3'd0, carry};
                carry = 1'b0;
            end
        end

        // digit chars, most significant first; leading zeros become spaces
        zero_acc = 1'b1;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            dig = eff_num[4*i +: 4];
            zero_acc = zero_acc && (dig == 4'd0);
            zero_from[i] = zero_acc;
            if (i > 0 && zero_acc) begin
                seq_next[NUMBER_DIGITS-1-i] = cts_pkg::CHAR_SPACE;
            end else begin
                seq_next[NUMBER_DIGITS-1-i] = cts_pkg::CHAR_ZERO + {4'd0, dig};
            end
        end

        // skip leading blanks beyond the six-wide field
        lead_cnt = '0;
        for (int i = NUMBER_DIGITS - 1; i >= PAD_W; i--) begin
            if (zero_from[i]) begin
                lead_cnt = lead_cnt + IDX_W'(1);
            end
        end

        seq_next[NUMBER_DIGITS] = cts_pkg::CHAR_TAB;

        ch = s_tdata;
        seq_next[NUMBER_DIGITS+1] = ch;
        seq_next[NUMBER_DIGITS+2] = ch;
        seq_next[NUMBER_DIGITS+3] = ch;
        seq_next[NUMBER_DIGITS+4] = ch;
        tail_len = 3'd1;
        priority if (cfg_reg.show_tabs && ch == cts_pkg::CHAR_TAB) begin
            seq_next[NUMBER_DIGITS+1] = cts_pkg::CHAR_CARET;
            seq_next[NUMBER_DIGITS+2] = cts_pkg::CHAR_I;
            tail_len = 3'd2;
        end else if (cfg_reg.show_ends && is_nl) begin
            seq_next[NUMBER_DIGITS+1] = cts_pkg::CHAR_DOLLAR;
            seq_next[NUMBER_DIGITS+2] = ch;
            tail_len = 3'd2;
        end else if (cfg_reg.show_nonprint && ch >= cts_pkg::META_LOW &&
                     ch < cts_pkg::META_HIGH) begin
            seq_next[NUMBER_DIGITS+1] = cts_pkg::CHAR_M;
            seq_next[NUMBER_DIGITS+2] = cts_pkg::CHAR_DASH;
            seq_next[NUMBER_DIGITS+3] = cts_pkg::CHAR_CARET;
            seq_next[NUMBER_DIGITS+4] = ch - cts_pkg::CARET_OFS;
            tail_len = 3'd4;
        end else if (cfg_reg.show_nonprint && ch >= cts_pkg::META_HIGH) begin
            seq_next[NUMBER_DIGITS+1] = cts_pkg::CHAR_M;
            seq_next[NUMBER_DIGITS+2] = cts_pkg::CHAR_DASH;
            seq_next[NUMBER_DIGITS+3] = ch - cts_pkg::META_OFS;
            tail_len = 3'd3;
        end else if (cfg_reg.show_nonprint && ch < cts_pkg::CTRL_LIMIT &&
                     ch != cts_pkg::CHAR_TAB && !is_nl) begin
            seq_next[NUMBER_DIGITS+1] = cts_pkg::CHAR_CARET;
            seq_next[NUMBER_DIGITS+2] = ch + cts_pkg::CARET_OFS;
            tail_len = 3'd2;
        end else if (cfg_reg.show_nonprint && ch == cts_pkg::CHAR_DEL) begin
            seq_next[NUMBER_DIGITS+1] = cts_pkg::CHAR_CARET;
            seq_next[NUMBER_DIGITS+2] = cts_pkg::CHAR_QMARK;
            tail_len = 3'd2;
        end else begin
            tail_len = 3'd1;
        end

        start_next = number_on ? lead_cnt : IDX_W'(NUMBER_DIGITS + 1);
        end_next   = IDX_W'(NUMBER_DIGITS) + IDX_W'(tail_len);
    end

    assign m_tvalid  = busy_reg;
    assign m_tdata   = seq_reg[idx_reg];
    assign m_tlast   = (idx_reg == end_reg);
    assign m_take    = m_tvalid && m_tready;
    assign last_take = m_take && m_tlast;
    assign s_tready  = !busy_reg || last_take;
    assign s_take    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cts_pkg::REG_NUMBER_ALL:      cfg_reg.number_all      <= cfg_wdata[0];
                cts_pkg::REG_NUMBER_NONBLANK: cfg_reg.number_nonblank <= cfg_wdata[0];
                cts_pkg::REG_SQUEEZE_BLANK:   cfg_reg.squeeze_blank   <= cfg_wdata[0];
                cts_pkg::REG_SHOW_ENDS:       cfg_reg.show_ends       <= cfg_wdata[0];
                cts_pkg::REG_SHOW_TABS:       cfg_reg.show_tabs       <= cfg_wdata[0];
                cts_pkg::REG_SHOW_NONPRINT:   cfg_reg.show_nonprint   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_nl_reg   <= 1'b1;
            blank_run_reg <= 2'd0;
            line_bcd_reg  <= BCD_W'(1);
        end else if (s_take) begin
            blank_run_reg <= run_next;
            if (drop) begin
                prev_nl_reg  <= eff_prev;
                line_bcd_reg <= eff_num;
            end else begin
                prev_nl_reg  <= is_nl;
                line_bcd_reg <= number_on ? num_inc : eff_num;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            end_reg  <= '0;
        end else if (s_take && !drop) begin
            busy_reg <= 1'b1;
            idx_reg  <= start_next;
            end_reg  <= end_next;
        end else if (last_take) begin
            busy_reg <= 1'b0;
        end else if (m_take) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // payload: load the whole expansion in one beat
    always_ff @(posedge aclk) begin
        if (s_take && !drop) begin
            for (int i = 0; i < SEQ_LEN; i++) begin
                seq_reg[i] <= seq_next[i];
            end
        end
    end

endmodule

// ----- rtl/core/cts_checker.sv -----
module cts_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [7:0]                    s_tdata,
    input logic [0:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [7:0]                    m_tdata,
    input logic                          m_tlast,
    input logic                          cfg_wr_en,
    input logic [cts_pkg::CFG_ADDR_W-1:0] cfg_index,
    input logic [0:0]                    cfg_wdata
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

    a_run_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken in the middle of a run");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("run ended without a last beat");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output beat changed");

endmodule

bind cat_text_stream_filter cts_checker u_cts_checker (.*);
